/* rtl/core/free_polyomino_equivalence_assert.svh */
// Assertion macros for the free polyomino equivalence checker.
`ifndef FREE_POLYOMINO_EQUIVALENCE_ASSERT_SVH
`define FREE_POLYOMINO_EQUIVALENCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/fpe_pkg.sv */
// Types, constants and point transforms for the free polyomino equivalence block.
package fpe_pkg;

	localparam int MAX_CELLS_DEF = 16;
	localparam int COORD_W       = 5;
	localparam int XF_W          = 6;
	localparam int TGT_W         = 7;
	localparam int N_XFORM       = 8;
	localparam logic [2:0] XFORM_LAST = 3'd7;

	// Item kinds on the input stream.
	localparam logic KIND_A = 1'b0;
	localparam logic KIND_B = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [XF_W-1:0]    xf_coord_t;
	typedef logic signed [TGT_W-1:0]   tgt_coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} cell_t;

	typedef struct packed {
		xf_coord_t y;
		xf_coord_t x;
	} xf_pt_t;

	typedef struct packed {
		tgt_coord_t y;
		tgt_coord_t x;
	} tgt_pt_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic rot_b;
	} cell_ctl_t;

	// Reflect across the y axis when bit 2 is set, then rotate a quarter turn
	// clockwise as many times as bits 1:0 say.
	function automatic xf_pt_t xform(input logic [2:0] t, input cell_t c);
		xf_coord_t x0;
		xf_coord_t y0;
		xf_pt_t    r;
		x0 = t[2] ? -XF_W'(c.x) : XF_W'(c.x);
		y0 = XF_W'(c.y);
		case (t[1:0])
			2'd0: begin
				r.x = x0;
				r.y = y0;
			end
			2'd1: begin
				r.x = y0;
				r.y = -x0;
			end
			2'd2: begin
				r.x = -x0;
				r.y = -y0;
			end
			default: begin
				r.x = -y0;
				r.y = x0;
			end
		endcase
		return r;
	endfunction

	// Lexicographic order: x first, then y.
	function automatic logic pt_less(input xf_pt_t a, input xf_pt_t b);
		return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
	endfunction

endpackage

/* rtl/core/free_polyomino_equivalence.sv */
// Top level of the free polyomino equivalence block.
// Input stream s_*: one cell per item. s_tuser is the kind (0 = shape A cell,
// 1 = shape B cell), s_tdata holds cell_x in bits 4:0 and cell_y in bits 9:5,
// s_tlast on a B cell ends the shape and starts the comparison.
// A full store drops the cell and flags overflow. After the last B cell the
// block checks the counts; unequal counts or two empty shapes go straight to
// the result. Otherwise it walks the B cells past the chain of A cells, one B
// cell per cycle, for each of the eight rotations and reflections, ending at
// the first transform whose cells all land in A, then posts the result once
// the output register is free. The B cells rotate through the cell chain.
// Output stream m_*: one item per comparison, m_tdata bit 0 = same,
// bit 1 = overflow. Loads are taken while a result waits; a stalled result
// holds the block only once the next comparison is done.
// Reset empties both stores and clears the overflow flag; both are emptied
// again after every result.
module free_polyomino_equivalence
	import fpe_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [4:0] cell_x, [9:5] cell_y, [15:10] zero
	input  logic        s_tuser,  // [0] kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] same, [1] overflow, [7:2] zero
);

	localparam int CNT_W = $clog2(MAX_CELLS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [2:0]       t_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_a_q;
	logic [CNT_W-1:0] cnt_b_q;
	logic             ok_q;
	logic             same_q;
	logic             ovf_q;
	logic             m_valid_q;
	logic             m_same_q;
	logic             m_ovf_q;

	logic      s_acc;
	logic      last_b;
	logic      room_a;
	logic      room_b;
	logic      drop;
	logic      finish;
	logic      found;
	logic      hit_all;
	logic      last_idx;
	cell_ctl_t ctl;
	cell_t     in_cell;
	cell_t     a_chain [MAX_CELLS];
	cell_t     b_chain [MAX_CELLS];
	logic [MAX_CELLS-1:0] match;
	xf_pt_t    a_anc;
	xf_pt_t    b_anc [N_XFORM];
	xf_pt_t    head_xf;
	xf_pt_t    sel_anc;
	tgt_pt_t   tgt;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign last_b   = s_acc && (s_tuser == KIND_B) && s_tlast;
	assign in_cell.x = s_tdata[4:0];
	assign in_cell.y = s_tdata[9:5];
	assign room_a   = (cnt_a_q < CNT_W'(MAX_CELLS));
	assign room_b   = (cnt_b_q < CNT_W'(MAX_CELLS));
	assign drop     = s_acc && ((s_tuser == KIND_B) ? !room_b : !room_a);

	assign ctl.load_a = s_acc && (s_tuser == KIND_A) && room_a;
	assign ctl.load_b = s_acc && (s_tuser == KIND_B) && room_b;
	assign ctl.rot_b  = (state_q == ST_SCAN);

	assign finish = (state_q == ST_FINISH) && (!m_valid_q || m_tready);

	// Anchors build up as cells load; dropped cells never reach them.
	fpe_anchor u_anchor_a (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (finish),
		.upd    (ctl.load_a),
		.pt     (xform(3'd0, in_cell)),
		.anchor (a_anc)
	);

	for (genvar t = 0; t < N_XFORM; t++) begin : g_anchor_b
		fpe_anchor u_anchor_b (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (finish),
			.upd    (ctl.load_b),
			.pt     (xform(3'(t), in_cell)),
			.anchor (b_anc[t])
		);
	end

	// The head B cell, transformed and moved into A's frame.
	assign head_xf = xform(t_q, b_chain[0]);
	assign sel_anc = b_anc[t_q];
	assign tgt.x = TGT_W'(head_xf.x) - TGT_W'(sel_anc.x) + TGT_W'(a_anc.x);
	assign tgt.y = TGT_W'(head_xf.y) - TGT_W'(sel_anc.y) + TGT_W'(a_anc.y);

	for (genvar j = 0; j < MAX_CELLS; j++) begin : g_cell
		cell_t a_prev;
		cell_t b_prev;
		cell_t b_next;
		if (j == 0) begin : g_first
			assign a_prev = in_cell;
			assign b_prev = in_cell;
		end else begin : g_rest
			assign a_prev = a_chain[j-1];
			assign b_prev = b_chain[j-1];
		end
		if (j == MAX_CELLS - 1) begin : g_end
			assign b_next = b_chain[0];
		end else begin : g_mid
			assign b_next = b_chain[j+1];
		end
		fpe_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.a_live (CNT_W'(j) < cnt_a_q),
			.b_wrap (CNT_W'(j) == (cnt_b_q - CNT_W'(1))),
			.a_prev (a_prev),
			.b_prev (b_prev),
			.b_next (b_next),
			.b_head (b_chain[0]),
			.tgt    (tgt),
			.a_cur  (a_chain[j]),
			.b_cur  (b_chain[j]),
			.match  (match[j])
		);
	end

	assign found    = |match;
	assign hit_all  = ((idx_q == '0) || ok_q) && found;
	assign last_idx = (idx_q == (cnt_b_q - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			t_q       <= '0;
			idx_q     <= '0;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			ok_q      <= 1'b0;
			same_q    <= 1'b0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
			m_same_q  <= 1'b0;
			m_ovf_q   <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !finish) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.load_a) begin
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
					if (ctl.load_b) begin
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end
					if (drop) begin
						ovf_q <= 1'b1;
					end
					if (last_b) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					t_q   <= '0;
					idx_q <= '0;
					ok_q  <= 1'b0;
					if (cnt_a_q != cnt_b_q) begin
						same_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else if (cnt_b_q == '0) begin
						same_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_idx) begin
						idx_q <= '0;
						if (hit_all) begin
							same_q  <= 1'b1;
							state_q <= ST_FINISH;
						end else if (t_q == XFORM_LAST) begin
							same_q  <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							t_q <= t_q + 3'd1;
						end
					end else begin
						ok_q  <= hit_all;
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					// Post the answer once the output register is free, then empty the stores.
					if (finish) begin
						m_valid_q <= 1'b1;
						m_same_q  <= same_q;
						m_ovf_q   <= ovf_q;
						cnt_a_q   <= '0;
						cnt_b_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_ovf_q, m_same_q};

endmodule

/* rtl/core/fpe_anchor.sv */
// Running anchor (lowest x, then lowest y) of the points loaded into one shape.
module fpe_anchor
	import fpe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   clear,
	input  logic   upd,
	input  xf_pt_t pt,
	output xf_pt_t anchor
);

	logic   have_q;
	xf_pt_t anchor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (clear) begin
			have_q <= 1'b0;
		end else if (upd) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && (!have_q || pt_less(pt, anchor_q))) begin
			anchor_q <= pt;
		end
	end

	assign anchor = anchor_q;

endmodule

/* rtl/core/fpe_cell.sv */
// One slot of the cell chain: holds one A cell and one B cell and tests A against the target.
module fpe_cell
	import fpe_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      a_live,
	input  logic      b_wrap,
	input  cell_t     a_prev,
	input  cell_t     b_prev,
	input  cell_t     b_next,
	input  cell_t     b_head,
	input  tgt_pt_t   tgt,
	output cell_t     a_cur,
	output cell_t     b_cur,
	output logic      match
);

	cell_t a_q;
	cell_t b_q;

	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			a_q <= a_prev;
		end
		// Rotate B toward the head; the last live slot takes the head back.
		if (ctl.rot_b) begin
			b_q <= b_wrap ? b_head : b_next;
		end else if (ctl.load_b) begin
			b_q <= b_prev;
		end
	end

	assign a_cur = a_q;
	assign b_cur = b_q;
	assign match = a_live && (TGT_W'(a_q.x) == tgt.x) && (TGT_W'(a_q.y) == tgt.y);

endmodule

/* rtl/core/fpe_checker.sv */
// Port-level checks for the free polyomino equivalence block, bound to the top level.
`include "free_polyomino_equivalence_assert.svh"

module fpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	`FPE_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`FPE_ASSERT_NXT(a_busy_after_last, clk, arst_n, s_tvalid && s_tready && s_tuser && s_tlast, !s_tready && !$rose(m_tvalid), "input taken or result posted right after last B cell")
	`FPE_ASSERT_IMP(a_ready_with_result, clk, arst_n, $rose(m_tvalid), s_tready, "result posted without returning to load")
	`FPE_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[7:2] == 6'b0, "result padding not zero")

endmodule

bind free_polyomino_equivalence fpe_checker u_fpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* dv/free_polyomino_equivalence_chk.sv */
// Scoreboard for the free polyomino equivalence block: mirrors both cell stores and checks each verdict.
`timescale 1ns / 1ps
module free_polyomino_equivalence_chk
	import fpe_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [4:0] cell_x, [9:5] cell_y, [15:10] zero
	input  logic        s_tuser,  // [0] kind
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // [0] same, [1] overflow, [7:2] zero
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic same;
		logic overflow;
	} verdict_t;

	int       a_x[MAX_CELLS];
	int       a_y[MAX_CELLS];
	int       b_x[MAX_CELLS];
	int       b_y[MAX_CELLS];
	int       a_count;
	int       b_count;
	logic     dropped;
	int       fails;
	coord_t   cx;
	coord_t   cy;
	verdict_t want;
	verdict_t verdict_q[$];

	// Corner cell: lowest x, then lowest y among cells sharing that x.
	function automatic void find_corner(input int xs[MAX_CELLS], input int ys[MAX_CELLS],
			input int n, output int kx, output int ky);
		kx = 0;
		ky = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || xs[i] < kx) begin
				kx = xs[i];
				ky = ys[i];
			end else if (xs[i] == kx && ys[i] < ky) begin
				ky = ys[i];
			end
		end
	endfunction

	function automatic logic shapes_congruent();
		int   tx[MAX_CELLS];
		int   ty[MAX_CELLS];
		int   ox, oy, px, py, x, y, tmp;
		logic all_in, hit;
		if (a_count != b_count)
			return 1'b0;
		find_corner(a_x, a_y, a_count, ox, oy);
		for (int t = 0; t < 8; t++) begin
			for (int i = 0; i < b_count; i++) begin
				x = (t & 4) ? -b_x[i] : b_x[i];
				y = b_y[i];
				for (int r = 0; r < (t & 3); r++) begin
					tmp = x;
					x = y;
					y = -tmp;
				end
				tx[i] = x;
				ty[i] = y;
			end
			find_corner(tx, ty, b_count, px, py);
			all_in = 1'b1;
			for (int i = 0; i < b_count; i++) begin
				hit = 1'b0;
				for (int j = 0; j < a_count; j++)
					if (a_x[j] - ox == tx[i] - px && a_y[j] - oy == ty[i] - py)
						hit = 1'b1;
				if (!hit)
					all_in = 1'b0;
			end
			if (all_in)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count = 0;
			b_count = 0;
			dropped = 1'b0;
			fails = 0;
			verdict_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// compare before loading so a verdict can never match its own trigger
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					fails++;
					$display("%0t ns: unexpected result, expected none, got same=%0b overflow=%0b",
						$time, m_tdata[0], m_tdata[1]);
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want.same) begin
						fails++;
						$display("%0t ns: same expected %0b, got %0b", $time, want.same, m_tdata[0]);
					end
					if (m_tdata[1] !== want.overflow) begin
						fails++;
						$display("%0t ns: overflow expected %0b, got %0b",
							$time, want.overflow, m_tdata[1]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				cx = s_tdata[4:0];
				cy = s_tdata[9:5];
				if (s_tuser == KIND_A) begin
					if (a_count < MAX_CELLS) begin
						a_x[a_count] = int'(cx);
						a_y[a_count] = int'(cy);
						a_count++;
					end else begin
						dropped = 1'b1;
					end
				end else begin
					if (b_count < MAX_CELLS) begin
						b_x[b_count] = int'(cx);
						b_y[b_count] = int'(cy);
						b_count++;
					end else begin
						dropped = 1'b1;
					end
					if (s_tlast) begin
						want.same = shapes_congruent();
						want.overflow = dropped;
						verdict_q = {verdict_q, want};
						a_count = 0;
						b_count = 0;
						dropped = 1'b0;
					end
				end
			end
			pending <= verdict_q.size();
			errors <= fails;
		end
	end

endmodule

/* dv/free_polyomino_equivalence_tb.sv */
// Testbench top for the free polyomino equivalence block: clock, reset, cell stimulus and verdict.
`timescale 1ns / 1ps
module free_polyomino_equivalence_tb
	import fpe_pkg::*;
();

	localparam int   ITEMS        = 1650;
	localparam int   CALM_ITEMS   = 150;
	localparam int   DRAIN_CYCLES = 8 * MAX_CELLS_DEF + 32;

	typedef struct {
		int x;
		int y;
	} pt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // [4:0] cell_x, [9:5] cell_y, [15:10] zero
	logic        s_tuser;  // [0] kind
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // [0] same, [1] overflow, [7:2] zero

	int  errors;
	int  pending;
	int  sent;
	bit  calm;
	bit  src_gaps;
	pt_t shape_a[$];
	pt_t shape_b[$];

	free_polyomino_equivalence uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	free_polyomino_equivalence_chk chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 30)) - 15;
	endfunction

	// Shift a shape to a random spot in the grid, often flush against an edge.
	function automatic void place(ref pt_t cells[$]);
		int lox, hix, loy, hiy, dx, dy;
		lox = cells[0].x;
		hix = lox;
		loy = cells[0].y;
		hiy = loy;
		foreach (cells[i]) begin
			if (cells[i].x < lox) lox = cells[i].x;
			if (cells[i].x > hix) hix = cells[i].x;
			if (cells[i].y < loy) loy = cells[i].y;
			if (cells[i].y > hiy) hiy = cells[i].y;
		end
		case ($urandom_range(0, 3))
			0: dx = -15 - lox;
			1: dx = 15 - hix;
			default: dx = int'($urandom_range(0, 30 - (hix - lox))) - 15 - lox;
		endcase
		case ($urandom_range(0, 3))
			0: dy = -15 - loy;
			1: dy = 15 - hiy;
			default: dy = int'($urandom_range(0, 30 - (hiy - loy))) - 15 - loy;
		endcase
		foreach (cells[i]) begin
			cells[i].x += dx;
			cells[i].y += dy;
		end
	endfunction

	// Grow a connected shape of n distinct cells from a seed cell, then place it in the grid.
	function automatic void grow_shape(ref pt_t cells[$], input int n);
		pt_t c;
		bit  taken;
		cells = {};
		c.x = 0;
		c.y = 0;
		cells = {cells, c};
		while (cells.size() < n) begin
			c = cells[$urandom_range(0, cells.size() - 1)];
			case ($urandom_range(0, 3))
				0: c.x++;
				1: c.x--;
				2: c.y++;
				default: c.y--;
			endcase
			taken = 1'b0;
			foreach (cells[i])
				if (cells[i].x == c.x && cells[i].y == c.y)
					taken = 1'b1;
			if (!taken)
				cells = {cells, c};
		end
		place(cells);
	endfunction

	task automatic send_cell(input logic kind, input int x, input int y, input logic last);
		coord_t cx;
		coord_t cy;
		cx = coord_t'(x);
		cy = coord_t'(y);
		calm = sent >= ITEMS - CALM_ITEMS;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'b0, cy, cx};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (!calm && src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Send a shape in random order; B closes with last, A gets a stray last now and then.
	task automatic send_shape(input pt_t cells[$], input logic kind);
		pt_t tmp;
		int  j;
		for (int i = cells.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = cells[i];
			cells[i] = cells[j];
			cells[j] = tmp;
		end
		foreach (cells[i]) begin
			if (kind == KIND_B)
				send_cell(KIND_B, cells[i].x, cells[i].y, i == cells.size() - 1);
			else
				send_cell(KIND_A, cells[i].x, cells[i].y, $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		bit sink_stalls;
		m_tready <= 1'b0;
		sink_stalls = 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				sink_stalls = !sink_stalls;
			if (!calm && sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		int   pick, r, n, t, k;
		logic kind;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_A;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		sent = 0;
		calm = 1'b0;
		src_gaps = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cells at opposite corners
		send_cell(KIND_A, -15, -15, 1'b0);
		send_cell(KIND_B, 15, 15, 1'b1);
		// empty A against one B cell
		send_cell(KIND_B, 0, 0, 1'b1);
		// straight tromino turned upright; last on an A cell is ignored
		send_cell(KIND_A, 0, 0, 1'b1);
		send_cell(KIND_A, 1, 0, 1'b0);
		send_cell(KIND_A, 2, 0, 1'b0);
		send_cell(KIND_B, 5, -15, 1'b0);
		send_cell(KIND_B, 5, -14, 1'b0);
		send_cell(KIND_B, 5, -13, 1'b1);
		// L tromino against its mirror image
		send_cell(KIND_A, -15, 15, 1'b0);
		send_cell(KIND_A, -15, 14, 1'b0);
		send_cell(KIND_A, -14, 15, 1'b0);
		send_cell(KIND_B, 15, 0, 1'b0);
		send_cell(KIND_B, 14, 0, 1'b0);
		send_cell(KIND_B, 14, 1, 1'b1);
		// repeated cells in both shapes
		send_cell(KIND_A, 3, 3, 1'b0);
		send_cell(KIND_A, 3, 3, 1'b0);
		send_cell(KIND_A, 4, 3, 1'b0);
		send_cell(KIND_B, -7, 2, 1'b0);
		send_cell(KIND_B, -7, 3, 1'b0);
		send_cell(KIND_B, -7, 3, 1'b1);
		// counts differ
		send_cell(KIND_A, 1, 1, 1'b0);
		send_cell(KIND_B, 1, 1, 1'b0);
		send_cell(KIND_B, 1, 2, 1'b1);

		while (sent < ITEMS) begin
			src_gaps = $urandom_range(0, 2) != 0;
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, 19);
			n = r < 12 ? $urandom_range(1, 6) : r < 17 ? $urandom_range(7, 12) :
				r < 19 ? $urandom_range(13, 16) : $urandom_range(17, 20);
			if (pick >= 90) begin
				// noise: cells of either kind in any order
				repeat ($urandom_range(0, 6)) begin
					kind = ($urandom_range(0, 1) == 1) ? KIND_B : KIND_A;
					send_cell(kind, rand_coord(), rand_coord(),
						kind == KIND_A && $urandom_range(0, 1) == 1);
				end
				send_cell(KIND_B, rand_coord(), rand_coord(), 1'b1);
			end else begin
				grow_shape(shape_a, n);
				if (pick >= 80) begin
					grow_shape(shape_b, n);
				end else begin
					shape_b = shape_a;
					t = $urandom_range(0, 7);
					foreach (shape_b[i]) begin
						if (t & 4)
							shape_b[i].x = -shape_b[i].x;
						repeat (t & 3) begin
							k = shape_b[i].x;
							shape_b[i].x = -shape_b[i].y;
							shape_b[i].y = k;
						end
					end
					place(shape_b);
					if (pick >= 70) begin
						// drop or duplicate a cell so the counts disagree
						if (n > 1 && $urandom_range(0, 1) == 1)
							void'(shape_b.pop_back());
						else
							shape_b = {shape_b, shape_b[0]};
					end else if (pick >= 55) begin
						k = $urandom_range(0, n - 1);
						shape_b[k].x = rand_coord();
						shape_b[k].y = rand_coord();
					end
				end
				send_shape(shape_a, KIND_A);
				send_shape(shape_b, KIND_B);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* free_polyomino_equivalence.f */
+incdir+rtl/core
rtl/core/fpe_pkg.sv
rtl/core/fpe_anchor.sv
rtl/core/fpe_cell.sv
rtl/core/free_polyomino_equivalence.sv
rtl/core/fpe_checker.sv
dv/free_polyomino_equivalence_chk.sv
dv/free_polyomino_equivalence_tb.sv
